>>> rtl/phec_pkg.sv
package phec_pkg;

    // Width of the byte offset counter inside a packet. The counter saturates at its
    // maximum, which lies beyond every header position that is parsed.
    localparam int COUNT_WIDTH = 8;
    localparam logic [COUNT_WIDTH-1:0] OFFSET_MAX = {COUNT_WIDTH{1'b1}};

    // Header positions, counted from the start of the packet or the start of a header.
    localparam logic [COUNT_WIDTH-1:0] ETH_TYPE_HI     = COUNT_WIDTH'(12);
    localparam logic [COUNT_WIDTH-1:0] ETH_TYPE_LO     = COUNT_WIDTH'(13);
    localparam logic [COUNT_WIDTH-1:0] ETH_NET_START   = COUNT_WIDTH'(14);
    localparam logic [COUNT_WIDTH-1:0] SLL_TYPE_HI     = COUNT_WIDTH'(14);
    localparam logic [COUNT_WIDTH-1:0] SLL_TYPE_LO     = COUNT_WIDTH'(15);
    localparam logic [COUNT_WIDTH-1:0] SLL_NET_START   = COUNT_WIDTH'(16);
    localparam logic [COUNT_WIDTH-1:0] RAW_NET_START   = COUNT_WIDTH'(0);
    localparam logic [COUNT_WIDTH-1:0] V4_PROTO_POS    = COUNT_WIDTH'(9);
    localparam logic [COUNT_WIDTH-1:0] V4_SRC_FIRST    = COUNT_WIDTH'(12);
    localparam logic [COUNT_WIDTH-1:0] V4_SRC_LAST     = COUNT_WIDTH'(15);
    localparam logic [COUNT_WIDTH-1:0] V4_DST_FIRST    = COUNT_WIDTH'(16);
    localparam logic [COUNT_WIDTH-1:0] V4_DST_LAST     = COUNT_WIDTH'(19);
    localparam logic [COUNT_WIDTH-1:0] V6_NEXT_HDR_POS = COUNT_WIDTH'(6);
    localparam logic [COUNT_WIDTH-1:0] V6_SRC_FIRST    = COUNT_WIDTH'(8);
    localparam logic [COUNT_WIDTH-1:0] V6_SRC_SPLIT    = COUNT_WIDTH'(16);
    localparam logic [COUNT_WIDTH-1:0] V6_SRC_LAST     = COUNT_WIDTH'(23);
    localparam logic [COUNT_WIDTH-1:0] V6_DST_FIRST    = COUNT_WIDTH'(24);
    localparam logic [COUNT_WIDTH-1:0] V6_DST_SPLIT    = COUNT_WIDTH'(32);
    localparam logic [COUNT_WIDTH-1:0] V6_DST_LAST     = COUNT_WIDTH'(39);
    localparam logic [COUNT_WIDTH-1:0] V6_HDR_LEN      = COUNT_WIDTH'(40);
    localparam logic [COUNT_WIDTH-1:0] L4_PORT0_LAST   = COUNT_WIDTH'(1);
    localparam logic [COUNT_WIDTH-1:0] L4_PORT1_LAST   = COUNT_WIDTH'(3);
    localparam logic [COUNT_WIDTH-1:0] TCP_FLAGS_POS   = COUNT_WIDTH'(13);
    localparam logic [COUNT_WIDTH:0]   TCP_HDR_LEN     = (COUNT_WIDTH+1)'(20);
    localparam logic [COUNT_WIDTH:0]   ICMP_HDR_LEN    = (COUNT_WIDTH+1)'(8);

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;
    localparam logic [3:0]  IP_VER_FIELD_4 = 4'd4;
    localparam logic [3:0]  IP_VER_FIELD_6 = 4'd6;
    localparam logic [3:0]  IHL_MIN        = 4'd5;
    localparam logic [7:0]  PROTO_ICMP     = 8'd1;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  ICMP_ECHO_REQ  = 8'd8;
    localparam logic [7:0]  ICMP_ECHO_REP  = 8'd0;
    localparam int          TCP_FLAG_SYN   = 1;
    localparam int          TCP_FLAG_ACK   = 4;
    localparam logic [2:0]  IP_VERSION_NONE = 3'd0;
    localparam logic [2:0]  IP_VERSION_4    = 3'd4;
    localparam logic [2:0]  IP_VERSION_6    = 3'd6;

    // Configuration register map.
    localparam int          APB_ADDR_WIDTH = 3;
    localparam logic        REG_LINK_KIND  = 1'b0;

    typedef enum logic [1:0] {
        LINK_ETH     = 2'd0,
        LINK_SLL     = 2'd1,
        LINK_RAW     = 2'd2,
        LINK_UNKNOWN = 2'd3
    } t_link_kind;

    typedef enum logic [1:0] {
        IP_NONE = 2'd0,
        IP_V4   = 2'd1,
        IP_V6   = 2'd2
    } t_ip_kind;

    typedef enum logic [1:0] {
        EVT_NONE       = 2'd0,
        EVT_TCP_SYN    = 2'd1,
        EVT_ECHO_REQ   = 2'd2,
        EVT_ECHO_REPLY = 2'd3
    } t_event_kind;

    typedef struct packed {
        t_event_kind event_kind;
        logic [2:0]  ip_version;
        logic [63:0] source_high;
        logic [63:0] source_low;
        logic [63:0] dest_high;
        logic [63:0] dest_low;
        logic [15:0] source_port;
        logic [15:0] dest_port;
    } t_result;

endpackage

>>> rtl/phec_apb_regs.sv
module phec_apb_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [phec_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    output phec_pkg::t_link_kind                o_link_kind
);
    import phec_pkg::*;

    t_link_kind r_link_kind;
    logic       wr_link;

    // The register index is the word address; the byte lanes below it are ignored.
    assign wr_link = psel && penable && pwrite && (paddr[APB_ADDR_WIDTH-1] == REG_LINK_KIND);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_kind <= LINK_ETH;
        end else if (wr_link) begin
            r_link_kind <= t_link_kind'(pwdata[1:0]);
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[APB_ADDR_WIDTH-1] == REG_LINK_KIND) begin
            prdata = {30'd0, r_link_kind};
        end
    end

    assign pready      = 1'b1;
    assign o_link_kind = r_link_kind;

endmodule

>>> rtl/phec_hdr_parser.sv
module phec_hdr_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    input  phec_pkg::t_link_kind i_link_kind,
    output phec_pkg::t_result    o_result
);
    import phec_pkg::*;

    logic [COUNT_WIDTH-1:0] r_offset, n_offset;
    logic [COUNT_WIDTH-1:0] r_net_start, n_net_start;
    logic [COUNT_WIDTH-1:0] r_trans_start, n_trans_start;
    logic [15:0]            r_ethertype, n_ethertype;
    t_ip_kind               r_ip_kind, n_ip_kind;
    logic [7:0]             r_proto, n_proto;
    logic [63:0]            r_src_hi, n_src_hi;
    logic [63:0]            r_src_lo, n_src_lo;
    logic [63:0]            r_dst_hi, n_dst_hi;
    logic [63:0]            r_dst_lo, n_dst_lo;
    logic [15:0]            r_port0, n_port0;
    logic [15:0]            r_port1, n_port1;
    logic [7:0]             r_tcp_flags, n_tcp_flags;
    logic [7:0]             r_icmp_type, n_icmp_type;
    logic                   r_trans_ok, n_trans_ok;

    logic [COUNT_WIDTH-1:0] pos;
    logic [COUNT_WIDTH-1:0] rel;
    logic [COUNT_WIDTH-1:0] trel;
    logic                   type_done;
    logic [COUNT_WIDTH-1:0] type_start;
    logic [COUNT_WIDTH:0]   total;
    t_event_kind            evt;

    always_comb begin
        n_net_start   = r_net_start;
        n_trans_start = r_trans_start;
        n_ethertype   = r_ethertype;
        n_ip_kind     = r_ip_kind;
        n_proto       = r_proto;
        n_src_hi      = r_src_hi;
        n_src_lo      = r_src_lo;
        n_dst_hi      = r_dst_hi;
        n_dst_lo      = r_dst_lo;
        n_port0       = r_port0;
        n_port1       = r_port1;
        n_tcp_flags   = r_tcp_flags;
        n_icmp_type   = r_icmp_type;
        n_trans_ok    = r_trans_ok;
        pos           = r_offset;
        rel           = '0;
        trel          = '0;
        type_done     = 1'b0;
        type_start    = '0;

        // Link layer: find the network protocol until it is known.
        if (r_ip_kind == IP_NONE) begin
            case (i_link_kind)
                LINK_ETH: begin
                    if (pos == ETH_TYPE_HI || pos == ETH_TYPE_LO) begin
                        n_ethertype = {r_ethertype[7:0], i_data_byte};
                        type_done   = (pos == ETH_TYPE_LO);
                        type_start  = ETH_NET_START;
                    end
                end
                LINK_SLL: begin
                    if (pos == SLL_TYPE_HI || pos == SLL_TYPE_LO) begin
                        n_ethertype = {r_ethertype[7:0], i_data_byte};
                        type_done   = (pos == SLL_TYPE_LO);
                        type_start  = SLL_NET_START;
                    end
                end
                LINK_RAW: begin
                    if (pos == RAW_NET_START) begin
                        if (i_data_byte[7:4] == IP_VER_FIELD_4) begin
                            n_ip_kind   = IP_V4;
                            n_net_start = RAW_NET_START;
                        end else if (i_data_byte[7:4] == IP_VER_FIELD_6) begin
                            n_ip_kind     = IP_V6;
                            n_net_start   = RAW_NET_START;
                            n_trans_start = RAW_NET_START + V6_HDR_LEN;
                            n_trans_ok    = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (type_done) begin
                if (n_ethertype == ETHERTYPE_IPV4) begin
                    n_ip_kind   = IP_V4;
                    n_net_start = type_start;
                end else if (n_ethertype == ETHERTYPE_IPV6) begin
                    n_ip_kind     = IP_V6;
                    n_net_start   = type_start;
                    n_trans_start = type_start + V6_HDR_LEN;
                    n_trans_ok    = 1'b1;
                end
            end
        end

        // Network layer. Raw IP decides the version on the same byte that carries the IHL.
        if (n_ip_kind != IP_NONE && pos >= n_net_start) begin
            rel = pos - n_net_start;
            if (n_ip_kind == IP_V4) begin
                if (rel == '0) begin
                    if (i_data_byte[3:0] >= IHL_MIN) begin
                        n_trans_start = n_net_start + COUNT_WIDTH'({i_data_byte[3:0], 2'b00});
                        n_trans_ok    = 1'b1;
                    end
                end else if (rel == V4_PROTO_POS) begin
                    n_proto = i_data_byte;
                end else if (rel >= V4_SRC_FIRST && rel <= V4_SRC_LAST) begin
                    n_src_lo = {32'd0, n_src_lo[23:0], i_data_byte};
                end else if (rel >= V4_DST_FIRST && rel <= V4_DST_LAST) begin
                    n_dst_lo = {32'd0, n_dst_lo[23:0], i_data_byte};
                end
            end else begin
                if (rel == V6_NEXT_HDR_POS) begin
                    n_proto = i_data_byte;
                end else if (rel >= V6_SRC_FIRST && rel <= V6_SRC_LAST) begin
                    if (rel >= V6_SRC_SPLIT) begin
                        n_src_lo = {n_src_lo[55:0], i_data_byte};
                    end else begin
                        n_src_hi = {n_src_hi[55:0], i_data_byte};
                    end
                end else if (rel >= V6_DST_FIRST && rel <= V6_DST_LAST) begin
                    if (rel >= V6_DST_SPLIT) begin
                        n_dst_lo = {n_dst_lo[55:0], i_data_byte};
                    end else begin
                        n_dst_hi = {n_dst_hi[55:0], i_data_byte};
                    end
                end
            end
        end

        // Transport layer: ICMP type, port pair and TCP flags.
        if (n_trans_ok && pos >= n_trans_start) begin
            trel = pos - n_trans_start;
            if (trel == '0) begin
                n_icmp_type = i_data_byte;
            end
            if (trel <= L4_PORT0_LAST) begin
                n_port0 = {n_port0[7:0], i_data_byte};
            end else if (trel <= L4_PORT1_LAST) begin
                n_port1 = {n_port1[7:0], i_data_byte};
            end else if (trel == TCP_FLAGS_POS) begin
                n_tcp_flags = i_data_byte;
            end
        end

        n_offset = (r_offset != OFFSET_MAX) ? r_offset + 1'b1 : r_offset;
    end

    // Classification on the final byte, using the fields as updated by that byte.
    always_comb begin
        total = {1'b0, pos} + 1'b1;
        evt   = EVT_NONE;
        if (n_trans_ok) begin
            if (n_proto == PROTO_TCP && total >= {1'b0, n_trans_start} + TCP_HDR_LEN) begin
                if (n_tcp_flags[TCP_FLAG_SYN] && !n_tcp_flags[TCP_FLAG_ACK]) begin
                    evt = EVT_TCP_SYN;
                end
            end else if (n_proto == PROTO_ICMP &&
                         total >= {1'b0, n_trans_start} + ICMP_HDR_LEN) begin
                if (n_icmp_type == ICMP_ECHO_REQ) begin
                    evt = EVT_ECHO_REQ;
                end else if (n_icmp_type == ICMP_ECHO_REP) begin
                    evt = EVT_ECHO_REPLY;
                end
            end
        end

        o_result = '0;
        if (evt != EVT_NONE) begin
            o_result.event_kind  = evt;
            o_result.ip_version  = (n_ip_kind == IP_V4) ? IP_VERSION_4 : IP_VERSION_6;
            o_result.source_high = n_src_hi;
            o_result.source_low  = n_src_lo;
            o_result.dest_high   = n_dst_hi;
            o_result.dest_low    = n_dst_lo;
            if (evt == EVT_TCP_SYN) begin
                o_result.source_port = n_port0;
                o_result.dest_port   = n_port1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last_byte)) begin
            r_offset      <= '0;
            r_net_start   <= '0;
            r_trans_start <= '0;
            r_ethertype   <= '0;
            r_ip_kind     <= IP_NONE;
            r_proto       <= '0;
            r_src_hi      <= '0;
            r_src_lo      <= '0;
            r_dst_hi      <= '0;
            r_dst_lo      <= '0;
            r_port0       <= '0;
            r_port1       <= '0;
            r_tcp_flags   <= '0;
            r_icmp_type   <= '0;
            r_trans_ok    <= 1'b0;
        end else if (i_step) begin
            r_offset      <= n_offset;
            r_net_start   <= n_net_start;
            r_trans_start <= n_trans_start;
            r_ethertype   <= n_ethertype;
            r_ip_kind     <= n_ip_kind;
            r_proto       <= n_proto;
            r_src_hi      <= n_src_hi;
            r_src_lo      <= n_src_lo;
            r_dst_hi      <= n_dst_hi;
            r_dst_lo      <= n_dst_lo;
            r_port0       <= n_port0;
            r_port1       <= n_port1;
            r_tcp_flags   <= n_tcp_flags;
            r_icmp_type   <= n_icmp_type;
            r_trans_ok    <= n_trans_ok;
        end
    end

endmodule

>>> rtl/packet_header_event_classifier.sv
// Packet header event classifier. Packet bytes enter one per beat on the input channel,
// with i_last_byte marking the final byte of each packet. The link_kind register (APB
// address 0) selects the framing: Ethernet, Linux cooked capture, raw IP, or an unknown
// kind that never classifies. Exactly one result beat leaves for every last byte and none
// for any other byte: it reports a TCP SYN without ACK, an ICMP echo request or an ICMP
// echo reply over IPv4 or IPv6 (where ICMP is recognized by next header 1), together
// with the addresses and, for TCP, the ports. When there is no event every output field
// is zero, which includes packets whose headers are cut short, IPv4 headers with an IHL
// below five and unknown framing. The block takes one byte per clock cycle, but a last
// byte stays in the input register while the result register is full and not taken.
// One input register holds the byte, the parser updates its header state from it,
// and the result register holds the event until the consumer takes it. A new byte is
// accepted while a result waits, unless the byte in the input register is the last of a
// packet. The link kind should be written only while no packet is in flight.
module packet_header_event_classifier (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [phec_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [7:0]                          i_data_byte,
    input  logic                                i_last_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_event_kind,
    output logic [2:0]                          o_ip_version,
    output logic [63:0]                         o_source_high,
    output logic [63:0]                         o_source_low,
    output logic [63:0]                         o_dest_high,
    output logic [63:0]                         o_dest_low,
    output logic [15:0]                         o_source_port,
    output logic [15:0]                         o_dest_port
);
    import phec_pkg::*;

    t_link_kind link_kind;
    t_result    parse_result;

    // Input register: one byte beat waiting for the parser.
    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic       r_in_last;

    // Result register.
    logic       r_out_valid;
    t_result    r_out;

    logic       out_free;
    logic       step;
    logic       in_take;

    // A byte that is not last leaves the input register at once. A last byte needs
    // room in the result register, which frees up in the same cycle it is taken.
    assign out_free   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && (!r_in_last || out_free);
    assign o_in_ready = !r_in_valid || step;
    assign in_take    = i_in_valid && o_in_ready;

    phec_apb_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_link_kind (link_kind)
    );

    phec_hdr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_data_byte (r_in_data),
        .i_last_byte (r_in_last),
        .i_link_kind (link_kind),
        .o_result    (parse_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_out <= parse_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_kind  = r_out.event_kind;
    assign o_ip_version  = r_out.ip_version;
    assign o_source_high = r_out.source_high;
    assign o_source_low  = r_out.source_low;
    assign o_dest_high   = r_out.dest_high;
    assign o_dest_low    = r_out.dest_low;
    assign o_source_port = r_out.source_port;
    assign o_dest_port   = r_out.dest_port;

endmodule

>>> rtl/phec_port_checker.sv
module phec_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_event_kind,
    input logic [2:0]  o_ip_version,
    input logic [63:0] o_source_high,
    input logic [63:0] o_source_low,
    input logic [63:0] o_dest_high,
    input logic [63:0] o_dest_low,
    input logic [15:0] o_source_port,
    input logic [15:0] o_dest_port
);
    import phec_pkg::*;

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_event_kind) &&
            $stable(o_source_low) && $stable(o_dest_low) && $stable(o_source_port))
        else $error("result beat changed while stalled");

    // No event means every field of the beat is zero.
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_kind == EVT_NONE |->
            o_ip_version == IP_VERSION_NONE && o_source_high == 64'd0 &&
            o_source_low == 64'd0 && o_dest_high == 64'd0 && o_dest_low == 64'd0 &&
            o_source_port == 16'd0 && o_dest_port == 16'd0)
        else $error("event none with nonzero fields");

    // An event always carries IP version four or six.
    a_event_version: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_kind != EVT_NONE |->
            o_ip_version == IP_VERSION_4 || o_ip_version == IP_VERSION_6)
        else $error("event without a valid IP version");

    // ICMP events carry no ports.
    a_icmp_ports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_kind == EVT_ECHO_REQ || o_event_kind == EVT_ECHO_REPLY) |->
            o_source_port == 16'd0 && o_dest_port == 16'd0)
        else $error("ICMP event with nonzero ports");

    // IPv4 addresses fit in the low 32 bits of the low fields.
    a_v4_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_ip_version == IP_VERSION_4 |->
            o_source_high == 64'd0 && o_dest_high == 64'd0 &&
            o_source_low[63:32] == 32'd0 && o_dest_low[63:32] == 32'd0)
        else $error("IPv4 address wider than 32 bits");

endmodule

bind packet_header_event_classifier phec_port_checker u_port_checker (.*);

>>> tb/packet_header_event_classifier_tb.sv
`timescale 1ns / 1ps

module packet_header_event_classifier_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import phec_pkg::*;

    // The only register, link_kind, sits at byte address zero.
    localparam logic [APB_ADDR_WIDTH-1:0] LINK_KIND_ADDR = APB_ADDR_WIDTH'(4 * REG_LINK_KIND);

    // Values used to shape packets. They are not decoded by the block, except for the
    // flag bits inside the TCP flag byte.
    localparam logic [7:0]  FLAGS_SYN      = 8'h02;
    localparam logic [7:0]  FLAGS_SYN_ACK  = 8'h12;
    localparam logic [7:0]  PROTO_ICMPV6   = 8'd58;
    localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
    localparam logic [3:0]  IP_VER_FIELD_BAD = 4'd5;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_WIDTH-1:0] paddr;
    logic [31:0]               pwdata;
    logic [31:0]               prdata;
    logic                      pready;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic [7:0]                i_data_byte;
    logic                      i_last_byte;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic [1:0]                o_event_kind;
    logic [2:0]                o_ip_version;
    logic [63:0]               o_source_high;
    logic [63:0]               o_source_low;
    logic [63:0]               o_dest_high;
    logic [63:0]               o_dest_low;
    logic [15:0]               o_source_port;
    logic [15:0]               o_dest_port;

    packet_header_event_classifier i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_event_kind  (o_event_kind),
        .o_ip_version  (o_ip_version),
        .o_source_high (o_source_high),
        .o_source_low  (o_source_low),
        .o_dest_high   (o_dest_high),
        .o_dest_low    (o_dest_low),
        .o_source_port (o_source_port),
        .o_dest_port   (o_dest_port)
    );

    // Header parse state kept by the testbench. It mirrors what the block has to
    // remember about the packet in flight and is cleared after every last byte.
    t_link_kind  link_setting;
    int          off_cnt;
    int          net_base;
    int          l4_base;
    logic [15:0] type_word;
    t_ip_kind    ip_sel;
    logic [7:0]  l4_proto;
    logic [63:0] src_addr [2];
    logic [63:0] dst_addr [2];
    logic [15:0] port_word [2];
    logic [7:0]  tcp_flags;
    logic [7:0]  icmp_type;
    bit          l4_valid;

    // Events the block owes us, oldest first, one per packet.
    t_result     expected_events [$];

    // Bytes of the packet that is about to be sent.
    logic [7:0]  frame_q [$];

    bit          idle_on = 1'b0;
    int          error_count = 0;
    int          bytes_sent = 0;
    int          frames_sent = 0;
    int          event_tally [4] = '{0, 0, 0, 0};

    // A 12 ns clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Safety net: even the slowest legal run ends far earlier than this.
    initial begin
        #10_000_000;
        $display("Timed out with %0d events still pending.", expected_events.size());
        $display("FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    function automatic void reset_parse_state();
        off_cnt      = 0;
        net_base     = 0;
        l4_base      = 0;
        type_word    = '0;
        ip_sel       = IP_NONE;
        l4_proto     = '0;
        src_addr[0]  = '0;
        src_addr[1]  = '0;
        dst_addr[0]  = '0;
        dst_addr[1]  = '0;
        port_word[0] = '0;
        port_word[1] = '0;
        tcp_flags    = '0;
        icmp_type    = '0;
        l4_valid     = 1'b0;
    endfunction

    // Advances the parse state by one accepted byte. On the last byte of a packet it
    // works out the event the block must report and queues it.
    function automatic void classify_byte(input logic [7:0] b, input logic last);
        int       pos;
        int       rel;
        int       trel;
        int       base;
        int       w;
        bit       type_done;
        t_ip_kind found;
        t_result  r;

        pos       = off_cnt;
        base      = 0;
        type_done = 1'b0;
        found     = IP_NONE;

        // Link layer: find the network header. Once the IP kind is known it sticks.
        if (ip_sel == IP_NONE) begin
            if (link_setting == LINK_ETH && (pos == ETH_TYPE_HI || pos == ETH_TYPE_LO)) begin
                type_word = {type_word[7:0], b};
                type_done = (pos == ETH_TYPE_LO);
                base      = ETH_NET_START;
            end else if (link_setting == LINK_SLL &&
                         (pos == SLL_TYPE_HI || pos == SLL_TYPE_LO)) begin
                type_word = {type_word[7:0], b};
                type_done = (pos == SLL_TYPE_LO);
                base      = SLL_NET_START;
            end else if (link_setting == LINK_RAW && pos == RAW_NET_START) begin
                base = RAW_NET_START;
                if (b[7:4] == IP_VER_FIELD_4) begin
                    found = IP_V4;
                end else if (b[7:4] == IP_VER_FIELD_6) begin
                    found = IP_V6;
                end
            end
            if (type_done) begin
                if (type_word == ETHERTYPE_IPV4) begin
                    found = IP_V4;
                end else if (type_word == ETHERTYPE_IPV6) begin
                    found = IP_V6;
                end
            end
            if (found != IP_NONE) begin
                ip_sel   = found;
                net_base = base;
                if (found == IP_V6) begin
                    l4_base  = base + V6_HDR_LEN;
                    l4_valid = 1'b1;
                end
            end
        end

        // Network layer: protocol and addresses. The IPv4 transport offset comes from
        // IHL and is only trusted when IHL covers at least the fixed header.
        if (ip_sel != IP_NONE && pos >= net_base) begin
            rel = pos - net_base;
            if (ip_sel == IP_V4) begin
                if (rel == 0) begin
                    if (b[3:0] >= IHL_MIN) begin
                        l4_base  = net_base + 4 * int'(b[3:0]);
                        l4_valid = 1'b1;
                    end
                end else if (rel == V4_PROTO_POS) begin
                    l4_proto = b;
                end else if (rel >= V4_SRC_FIRST && rel <= V4_SRC_LAST) begin
                    src_addr[1] = {32'd0, src_addr[1][23:0], b};
                end else if (rel >= V4_DST_FIRST && rel <= V4_DST_LAST) begin
                    dst_addr[1] = {32'd0, dst_addr[1][23:0], b};
                end
            end else begin
                if (rel == V6_NEXT_HDR_POS) begin
                    l4_proto = b;
                end else if (rel >= V6_SRC_FIRST && rel <= V6_SRC_LAST) begin
                    w = (rel >= V6_SRC_SPLIT) ? 1 : 0;
                    src_addr[w] = {src_addr[w][55:0], b};
                end else if (rel >= V6_DST_FIRST && rel <= V6_DST_LAST) begin
                    w = (rel >= V6_DST_SPLIT) ? 1 : 0;
                    dst_addr[w] = {dst_addr[w][55:0], b};
                end
            end
        end

        // Transport layer: ICMP type, ports and the TCP flag byte.
        if (l4_valid && pos >= l4_base) begin
            trel = pos - l4_base;
            if (trel == 0) begin
                icmp_type = b;
            end
            if (trel <= L4_PORT0_LAST) begin
                port_word[0] = {port_word[0][7:0], b};
            end else if (trel <= L4_PORT1_LAST) begin
                port_word[1] = {port_word[1][7:0], b};
            end else if (trel == TCP_FLAGS_POS) begin
                tcp_flags = b;
            end
        end

        if (!last) begin
            if (off_cnt < OFFSET_MAX) begin
                off_cnt++;
            end
            return;
        end

        // The event only counts when the whole transport header arrived.
        r = '0;
        if (l4_valid) begin
            if (l4_proto == PROTO_TCP && pos + 1 >= l4_base + int'(TCP_HDR_LEN)) begin
                if (tcp_flags[TCP_FLAG_SYN] && !tcp_flags[TCP_FLAG_ACK]) begin
                    r.event_kind = EVT_TCP_SYN;
                end
            end else if (l4_proto == PROTO_ICMP && pos + 1 >= l4_base + int'(ICMP_HDR_LEN)) begin
                if (icmp_type == ICMP_ECHO_REQ) begin
                    r.event_kind = EVT_ECHO_REQ;
                end else if (icmp_type == ICMP_ECHO_REP) begin
                    r.event_kind = EVT_ECHO_REPLY;
                end
            end
        end
        if (r.event_kind != EVT_NONE) begin
            r.ip_version  = (ip_sel == IP_V4) ? IP_VERSION_4 : IP_VERSION_6;
            r.source_high = src_addr[0];
            r.source_low  = src_addr[1];
            r.dest_high   = dst_addr[0];
            r.dest_low    = dst_addr[1];
            if (r.event_kind == EVT_TCP_SYN) begin
                r.source_port = port_word[0];
                r.dest_port   = port_word[1];
            end
        end
        expected_events.push_back(r);
        reset_parse_state();
    endfunction

    // One register transfer: setup cycle, then access cycle. Read data is taken at the
    // edge that completes the access.
    task automatic apb_transfer(input logic write, input logic [31:0] wdata,
                                output logic [31:0] rdata);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = write;
        paddr   = LINK_KIND_ADDR;
        pwdata  = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        if (write) begin
            link_setting = t_link_kind'(wdata[1:0]);
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Lets the block go idle, then writes link_kind and reads it back. The extra
    // cycles cover a byte that is still inside the pipeline without a result.
    task automatic configure_link(input t_link_kind kind);
        logic [31:0] readback;
        i_in_valid = 1'b0;
        while (expected_events.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        apb_transfer(1'b1, 32'(kind), readback);
        apb_transfer(1'b0, '0, readback);
        if (readback[1:0] !== kind) begin
            report_mismatch("link_kind readback", readback, kind);
        end
    endtask

    // Sends one byte beat. Valid stays high after acceptance so that back-to-back
    // beats need no extra edge; it only drops for an idle burst.
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (idle_on && $urandom_range(0, 9) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_data_byte = b;
        i_last_byte = last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        classify_byte(b, last);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame();
        int n;
        n = frame_q.size();
        for (int k = 0; k < n; k++) begin
            send_byte(frame_q[k], k == n - 1);
        end
        frames_sent++;
    endtask

    function automatic void add_noise(input int n);
        repeat (n) frame_q.push_back(8'($urandom));
    endfunction

    // Builds and sends one packet. Framing other than cooked capture or raw IP gets an
    // Ethernet header. A version other than six gets an IPv4-shaped header carrying
    // that version nibble. keep_len, when nonzero, cuts the packet to that length.
    task automatic send_packet(input t_link_kind framing, input logic [3:0] ipv,
                               input logic [3:0] ihl, input logic [7:0] proto,
                               input logic [7:0] l4_code, input int payload_len,
                               input int keep_len);
        logic [15:0] etype;
        frame_q.delete();
        if (ipv == IP_VER_FIELD_4) begin
            etype = ETHERTYPE_IPV4;
        end else if (ipv == IP_VER_FIELD_6) begin
            etype = ETHERTYPE_IPV6;
        end else begin
            etype = $urandom_range(0, 1) ? ETHERTYPE_ARP : 16'($urandom);
        end
        if (framing == LINK_SLL) begin
            add_noise(14);
            frame_q.push_back(etype[15:8]);
            frame_q.push_back(etype[7:0]);
        end else if (framing != LINK_RAW) begin
            add_noise(12);
            frame_q.push_back(etype[15:8]);
            frame_q.push_back(etype[7:0]);
        end
        if (ipv == IP_VER_FIELD_6) begin
            frame_q.push_back({IP_VER_FIELD_6, 4'($urandom)});
            add_noise(5);
            frame_q.push_back(proto);
            add_noise(33);
        end else begin
            frame_q.push_back({ipv, ihl});
            add_noise(8);
            frame_q.push_back(proto);
            add_noise(10);
            if (ihl > IHL_MIN) begin
                add_noise(4 * (int'(ihl) - int'(IHL_MIN)));
            end
        end
        // The flag byte sits at offset 13 of a TCP header; for ICMP the code goes
        // first, as the message type.
        if (proto == PROTO_TCP) begin
            add_noise(13);
            frame_q.push_back(l4_code);
            add_noise(6);
        end else begin
            frame_q.push_back(l4_code);
            add_noise(7);
        end
        add_noise(payload_len);
        if (keep_len > 0) begin
            while (frame_q.size() > keep_len) void'(frame_q.pop_back());
        end
        send_frame();
    endtask

    // Random traffic: mostly well-formed packets with random content, some with the
    // wrong framing, odd versions, protocols, flags, options or cut short, and a few
    // made of pure noise.
    task automatic send_random_packet(input t_link_kind framing);
        int          roll;
        t_link_kind  shape;
        logic [3:0]  ver;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [7:0]  code;
        int          payload_len;
        int          keep_len;

        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            frame_q.delete();
            add_noise($urandom_range(1, 48));
            send_frame();
        end else begin
            shape = (roll < 14) ? t_link_kind'($urandom_range(0, 2)) : framing;

            roll = $urandom_range(0, 19);
            if (roll < 10) begin
                ver = IP_VER_FIELD_4;
            end else if (roll < 18) begin
                ver = IP_VER_FIELD_6;
            end else begin
                ver = 4'($urandom);
                if (ver == IP_VER_FIELD_4 || ver == IP_VER_FIELD_6) begin
                    ver = IP_VER_FIELD_BAD;
                end
            end

            roll = $urandom_range(0, 19);
            if (roll < 9) begin
                proto = PROTO_TCP;
            end else if (roll < 18) begin
                proto = PROTO_ICMP;
            end else if (roll == 18) begin
                proto = PROTO_ICMPV6;
            end else begin
                proto = 8'($urandom);
            end

            roll = $urandom_range(0, 3);
            code = 8'($urandom);
            if (proto == PROTO_TCP && roll == 0) begin
                code = FLAGS_SYN;
            end else if (proto == PROTO_TCP && roll == 1) begin
                code = FLAGS_SYN_ACK;
            end else if (proto == PROTO_ICMP && roll == 0) begin
                code = ICMP_ECHO_REQ;
            end else if (proto == PROTO_ICMP && roll == 1) begin
                code = ICMP_ECHO_REP;
            end

            roll = $urandom_range(0, 19);
            if (roll < 15) begin
                ihl = IHL_MIN;
            end else if (roll < 18) begin
                ihl = 4'($urandom_range(6, 15));
            end else begin
                ihl = 4'($urandom_range(0, 4));
            end

            payload_len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 10)
                                                     : $urandom_range(0, 40);
            keep_len    = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 90) : 0;
            send_packet(shape, ver, ihl, proto, code, payload_len, keep_len);
        end
    endtask

    // The register comes out of reset as Ethernet and holds every value written.
    task automatic test_register_access();
        logic [31:0] readback;
        apb_transfer(1'b0, '0, readback);
        if (readback[1:0] !== LINK_ETH) begin
            report_mismatch("link_kind after reset", readback, LINK_ETH);
        end
        configure_link(LINK_UNKNOWN);
        configure_link(LINK_RAW);
        configure_link(LINK_SLL);
        configure_link(LINK_ETH);
    endtask

    // Every event kind over Ethernet, plus flag and type values that give no event.
    task automatic test_ethernet_events();
        configure_link(LINK_ETH);
        send_packet(LINK_ETH, IP_VER_FIELD_4, IHL_MIN, PROTO_TCP, FLAGS_SYN, 0, 0);
        send_packet(LINK_ETH, IP_VER_FIELD_4, IHL_MIN, PROTO_TCP, FLAGS_SYN_ACK, 3, 0);
        send_packet(LINK_ETH, IP_VER_FIELD_4, IHL_MIN, PROTO_ICMP, ICMP_ECHO_REQ, 6, 0);
        send_packet(LINK_ETH, IP_VER_FIELD_4, IHL_MIN, PROTO_ICMP, ICMP_ECHO_REP, 0, 0);
        send_packet(LINK_ETH, IP_VER_FIELD_4, IHL_MIN, PROTO_ICMP, 8'd3, 0, 0);
        send_packet(LINK_ETH, IP_VER_FIELD_6, IHL_MIN, PROTO_TCP, 8'hEF, 2, 0);
        send_packet(LINK_ETH, IP_VER_FIELD_6, IHL_MIN, PROTO_TCP, 8'hFF, 0, 0);
        send_packet(LINK_ETH, IP_VER_FIELD_BAD, IHL_MIN, PROTO_TCP, FLAGS_SYN, 0, 0);
    endtask

    // Cooked capture and raw IP, including a maximal IHL and a bad version nibble.
    task automatic test_cooked_and_raw();
        configure_link(LINK_SLL);
        send_packet(LINK_SLL, IP_VER_FIELD_4, IHL_MIN, PROTO_ICMP, ICMP_ECHO_REQ, 0, 0);
        send_packet(LINK_SLL, IP_VER_FIELD_6, IHL_MIN, PROTO_TCP, FLAGS_SYN, 5, 0);
        configure_link(LINK_RAW);
        send_packet(LINK_RAW, IP_VER_FIELD_4, 4'd15, PROTO_TCP, FLAGS_SYN, 0, 0);
        send_packet(LINK_RAW, IP_VER_FIELD_6, IHL_MIN, PROTO_ICMP, ICMP_ECHO_REP, 1, 0);
        send_packet(LINK_RAW, IP_VER_FIELD_BAD, IHL_MIN, PROTO_ICMP, ICMP_ECHO_REQ, 0, 0);
    endtask

    // Packets that end one byte short of a full transport header give no event, and
    // exactly full ones do. Also IHL below five and a one-byte packet.
    task automatic test_short_headers();
        configure_link(LINK_ETH);
        send_packet(LINK_ETH, IP_VER_FIELD_4, IHL_MIN, PROTO_TCP, FLAGS_SYN, 0, 53);
        send_packet(LINK_ETH, IP_VER_FIELD_4, IHL_MIN, PROTO_TCP, FLAGS_SYN, 0, 54);
        send_packet(LINK_ETH, IP_VER_FIELD_4, IHL_MIN, PROTO_ICMP, ICMP_ECHO_REQ, 0, 41);
        send_packet(LINK_ETH, IP_VER_FIELD_4, IHL_MIN, PROTO_ICMP, ICMP_ECHO_REQ, 0, 42);
        send_packet(LINK_ETH, IP_VER_FIELD_6, IHL_MIN, PROTO_TCP, FLAGS_SYN, 0, 30);
        send_packet(LINK_ETH, IP_VER_FIELD_4, IHL_MIN, PROTO_TCP, FLAGS_SYN, 0, 1);
        configure_link(LINK_RAW);
        send_packet(LINK_RAW, IP_VER_FIELD_4, 4'd4, PROTO_TCP, FLAGS_SYN, 8, 0);
        send_packet(LINK_RAW, IP_VER_FIELD_4, 4'd0, PROTO_ICMP, ICMP_ECHO_REQ, 8, 0);
    endtask

    // Over IPv6 an ICMP event is keyed on next header 1; the ICMPv6 number is ignored.
    task automatic test_ipv6_icmp();
        configure_link(LINK_ETH);
        send_packet(LINK_ETH, IP_VER_FIELD_6, IHL_MIN, PROTO_ICMP, ICMP_ECHO_REQ, 0, 0);
        send_packet(LINK_ETH, IP_VER_FIELD_6, IHL_MIN, PROTO_ICMPV6, ICMP_ECHO_REQ, 0, 0);
    endtask

    // With the unknown link kind nothing ever classifies.
    task automatic test_unknown_link();
        configure_link(LINK_UNKNOWN);
        send_packet(LINK_ETH, IP_VER_FIELD_4, IHL_MIN, PROTO_TCP, FLAGS_SYN, 0, 0);
        send_packet(LINK_RAW, IP_VER_FIELD_4, IHL_MIN, PROTO_ICMP, ICMP_ECHO_REP, 0, 0);
    endtask

    // Packets longer than the byte counter can count; the counter must saturate.
    task automatic test_long_packet();
        configure_link(LINK_ETH);
        send_packet(LINK_ETH, IP_VER_FIELD_4, IHL_MIN, PROTO_TCP, FLAGS_SYN, 250, 0);
        configure_link(LINK_RAW);
        send_packet(LINK_RAW, IP_VER_FIELD_6, IHL_MIN, PROTO_ICMP, ICMP_ECHO_REQ, 300, 0);
    endtask

    // Phases of random traffic under random link kinds, each with or without idling,
    // and a closing phase with both sides running flat out.
    task automatic test_random_traffic();
        int         goal_bytes;
        int         frames;
        t_link_kind framing;

        goal_bytes = bytes_sent + 1600;
        frames     = 0;
        while (bytes_sent < goal_bytes || frames < 48) begin
            framing = ($urandom_range(0, 7) == 0) ? LINK_UNKNOWN
                                                  : t_link_kind'($urandom_range(0, 2));
            idle_on = ($urandom_range(0, 3) != 0);
            configure_link(framing);
            repeat ($urandom_range(3, 8)) begin
                send_random_packet(framing);
                frames++;
            end
        end
        idle_on = 1'b0;
        framing = t_link_kind'($urandom_range(0, 2));
        configure_link(framing);
        repeat (8) send_random_packet(framing);
    endtask

    // Result side: the consumer stalls in random bursts while idling is enabled.
    initial begin
        i_out_ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
        end
    end

    // Every result beat is checked field by field against the oldest pending event.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_events.size() == 0) begin
                report_mismatch("result beat with nothing pending", o_event_kind, '0);
            end else begin
                want = expected_events.pop_front();
                event_tally[want.event_kind]++;
                if (o_event_kind !== want.event_kind) begin
                    report_mismatch("event_kind", o_event_kind, want.event_kind);
                end
                if (o_ip_version !== want.ip_version) begin
                    report_mismatch("ip_version", o_ip_version, want.ip_version);
                end
                if (o_source_high !== want.source_high) begin
                    report_mismatch("source_high", o_source_high, want.source_high);
                end
                if (o_source_low !== want.source_low) begin
                    report_mismatch("source_low", o_source_low, want.source_low);
                end
                if (o_dest_high !== want.dest_high) begin
                    report_mismatch("dest_high", o_dest_high, want.dest_high);
                end
                if (o_dest_low !== want.dest_low) begin
                    report_mismatch("dest_low", o_dest_low, want.dest_low);
                end
                if (o_source_port !== want.source_port) begin
                    report_mismatch("source_port", o_source_port, want.source_port);
                end
                if (o_dest_port !== want.dest_port) begin
                    report_mismatch("dest_port", o_dest_port, want.dest_port);
                end
            end
        end
    end

    initial begin
        int drain_wait;

        // All inputs start known; reset is applied once.
        i_rst_n     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        i_in_valid  = 1'b0;
        i_data_byte = '0;
        i_last_byte = 1'b0;
        link_setting = LINK_ETH;
        reset_parse_state();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        idle_on = 1'b1;

        test_register_access();
        test_ethernet_events();
        test_cooked_and_raw();
        test_short_headers();
        test_ipv6_icmp();
        test_unknown_link();
        test_long_packet();
        test_random_traffic();

        // Drain: wait for the last events, then watch for stray beats.
        i_in_valid = 1'b0;
        drain_wait = 0;
        while (expected_events.size() != 0 && drain_wait < 5000) begin
            @(negedge i_clk);
            drain_wait++;
        end
        repeat (10) @(negedge i_clk);
        if (expected_events.size() != 0) begin
            report_mismatch("events never delivered", expected_events.size(), '0);
        end

        $display("Sent %0d packets (%0d bytes) under all four link kinds.",
                 frames_sent, bytes_sent);
        $display("Results: %0d TCP SYN, %0d echo request, %0d echo reply, %0d without event.",
                 event_tally[EVT_TCP_SYN], event_tally[EVT_ECHO_REQ],
                 event_tally[EVT_ECHO_REPLY], event_tally[EVT_NONE]);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
